>>> hw/rtl/fault_greens_to_moment_tensor_top_macros.svh
// Assertion macros used by the Green's function rotator top level.
`ifndef FAULT_GREENS_TO_MOMENT_TENSOR_TOP_MACROS_SVH
`define FAULT_GREENS_TO_MOMENT_TENSOR_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define GTM_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define GTM_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/gtm_pkg.sv
// Shared constants and types for the Green's function to moment tensor rotator.
`default_nettype none

package gtm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 16;

  localparam int NUM_TRACES       = 10;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int MODE_WIDTH       = 2;
  localparam int CHANNEL_WIDTH    = 2;

  // Reset value of the cosine registers, truncated to the coefficient width.
  localparam int COEF_ONE         = 32767;
  localparam logic [MODE_WIDTH-1:0] MODE_RESET = 2'd1;

  // Trace positions inside a packed sample, first field at the top.
  localparam int TR_RSS = 0;
  localparam int TR_RDS = 1;
  localparam int TR_RDD = 2;
  localparam int TR_REP = 3;
  localparam int TR_ZSS = 4;
  localparam int TR_ZDS = 5;
  localparam int TR_ZDD = 6;
  localparam int TR_ZEP = 7;
  localparam int TR_TSS = 8;
  localparam int TR_TDS = 9;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_TENSOR_MODE        = 3'd0,
    REG_COS_AZIMUTH        = 3'd1,
    REG_SIN_AZIMUTH        = 3'd2,
    REG_COS_DOUBLE_AZIMUTH = 3'd3,
    REG_SIN_DOUBLE_AZIMUTH = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ISO  = 2'd0,
    MODE_DEV  = 2'd1,
    MODE_FULL = 2'd2
  } mode_t;

  typedef enum logic [CHANNEL_WIDTH-1:0] {
    CH_RADIAL     = 2'd0,
    CH_VERTICAL   = 2'd1,
    CH_TRANSVERSE = 2'd2
  } ch_t;

endpackage

`default_nettype wire

>>> hw/rtl/gtm_ifs.sv
// Sample and result stream interfaces of the rotator.
`default_nettype none

interface gtm_sample_if #(
  parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] radial_strike_slip;
  logic signed [SAMPLE_WIDTH-1:0] radial_dip_slip;
  logic signed [SAMPLE_WIDTH-1:0] radial_dip_45;
  logic signed [SAMPLE_WIDTH-1:0] radial_explosion;
  logic signed [SAMPLE_WIDTH-1:0] vertical_strike_slip;
  logic signed [SAMPLE_WIDTH-1:0] vertical_dip_slip;
  logic signed [SAMPLE_WIDTH-1:0] vertical_dip_45;
  logic signed [SAMPLE_WIDTH-1:0] vertical_explosion;
  logic signed [SAMPLE_WIDTH-1:0] transverse_strike_slip;
  logic signed [SAMPLE_WIDTH-1:0] transverse_dip_slip;

  modport source (
    output valid, radial_strike_slip, radial_dip_slip, radial_dip_45, radial_explosion,
           vertical_strike_slip, vertical_dip_slip, vertical_dip_45, vertical_explosion,
           transverse_strike_slip, transverse_dip_slip,
    input  ready
  );
  modport sink (
    input  valid, radial_strike_slip, radial_dip_slip, radial_dip_45, radial_explosion,
           vertical_strike_slip, vertical_dip_slip, vertical_dip_45, vertical_explosion,
           transverse_strike_slip, transverse_dip_slip,
    output ready
  );
endinterface

interface gtm_result_if #(
  parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [gtm_pkg::CHANNEL_WIDTH-1:0]    channel;
  logic signed [SAMPLE_WIDTH-1:0]       elem_xx;
  logic signed [SAMPLE_WIDTH-1:0]       elem_xy;
  logic signed [SAMPLE_WIDTH-1:0]       elem_xz;
  logic signed [SAMPLE_WIDTH-1:0]       elem_yy;
  logic signed [SAMPLE_WIDTH-1:0]       elem_yz;
  logic signed [SAMPLE_WIDTH-1:0]       elem_zz;
  logic                                 last_of_sample;

  modport source (
    output valid, channel, elem_xx, elem_xy, elem_xz, elem_yy, elem_yz, elem_zz,
           last_of_sample,
    input  ready
  );
  modport sink (
    input  valid, channel, elem_xx, elem_xy, elem_xz, elem_yy, elem_yz, elem_zz,
           last_of_sample,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/fault_greens_to_moment_tensor_top.sv
// Top level of the Green's function to moment tensor rotator.
//
// samples: one beat carries one time sample of the ten fault Green's traces.
// results: three beats per sample, radial, vertical, then transverse; each
//   holds six saturated tensor-element responses, and last_of_sample marks the
//   transverse beat.
// cfg: write tensor_mode and the azimuth sine/cosine terms by index while idle.
// A sample passes through the queue, the product stage and the output register
//   as its radial result; vertical and transverse follow when the receiver is ready.
// The back end builds one channel result per cycle unless the receiver stalls,
//   through a product stage and a sum stage, and takes the next sample after transverse.
// A two-entry queue lets samples keep arriving while a result waits.
// When the receiver stalls, the output register holds its beat and the back
//   end freezes; samples are refused only once the queue is full.
// Reset clears the queue and pipeline and loads mode deviatoric, cosines near
//   one and sines zero.
`default_nettype none

`include "fault_greens_to_moment_tensor_top_macros.svh"

module fault_greens_to_moment_tensor_top #(
  parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = gtm_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  gtm_sample_if.sink                               samples,
  gtm_result_if.source                             results,
  input  wire logic                                cfg_we,
  input  wire logic [gtm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]               cfg_data
);

  localparam int ITEM_W = gtm_pkg::NUM_TRACES * SAMPLE_WIDTH;

  gtm_pkg::mode_t                 mode;
  logic signed [COEF_WIDTH-1:0]   cos_az;
  logic signed [COEF_WIDTH-1:0]   sin_az;
  logic signed [COEF_WIDTH-1:0]   cos_2az;
  logic signed [COEF_WIDTH-1:0]   sin_2az;
  logic                           push_valid;
  logic                           push_ready;
  logic [ITEM_W-1:0]              push_data;
  logic                           pop_valid;
  logic                           pop_ready;
  logic [ITEM_W-1:0]              pop_data;

  gtm_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .cos_az    (cos_az),
    .sin_az    (sin_az),
    .cos_2az   (cos_2az),
    .sin_2az   (sin_2az),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  gtm_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(gtm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  gtm_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(pop_valid),
    .item_ready(pop_ready),
    .item_data (pop_data),
    .mode      (mode),
    .cos_az    (cos_az),
    .sin_az    (sin_az),
    .cos_2az   (cos_2az),
    .sin_2az   (sin_2az),
    .results   (results)
  );

  `GTM_ASSERT_NOW(a_transverse_zz_zero, clk, rst, results.valid && results.channel == gtm_pkg::CH_TRANSVERSE, results.elem_zz == '0, "transverse zz element is not zero")
  `GTM_ASSERT_NEXT(a_sample_order, clk, rst, results.valid && results.ready && results.channel == gtm_pkg::CH_TRANSVERSE, !results.valid || results.channel == gtm_pkg::CH_RADIAL, "result after transverse is not radial")
  `GTM_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !results.valid, "result beat shown right after reset")

endmodule

`default_nettype wire

>>> hw/rtl/gtm_front.sv
// Front end: configuration registers, mode decode and sample intake.
`default_nettype none

module gtm_front #(
  parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = gtm_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  gtm_sample_if.sink                                     samples,
  input  wire logic                                      cfg_we,
  input  wire logic [gtm_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
  input  wire logic [COEF_WIDTH-1:0]                     cfg_data,
  output gtm_pkg::mode_t                                 mode,
  output logic signed [COEF_WIDTH-1:0]                   cos_az,
  output logic signed [COEF_WIDTH-1:0]                   sin_az,
  output logic signed [COEF_WIDTH-1:0]                   cos_2az,
  output logic signed [COEF_WIDTH-1:0]                   sin_2az,
  output logic                                           push_valid,
  input  wire logic                                      push_ready,
  output logic [gtm_pkg::NUM_TRACES*SAMPLE_WIDTH-1:0]    push_data
);

  localparam logic [COEF_WIDTH-1:0] COEF_RESET = COEF_WIDTH'(gtm_pkg::COEF_ONE);

  logic [gtm_pkg::MODE_WIDTH-1:0] mode_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= gtm_pkg::MODE_RESET;
      cos_az   <= COEF_RESET;
      sin_az   <= '0;
      cos_2az  <= COEF_RESET;
      sin_2az  <= '0;
    end else if (cfg_we) begin
      case (gtm_pkg::cfg_reg_t'(cfg_index))
        gtm_pkg::REG_TENSOR_MODE:        mode_reg <= cfg_data[gtm_pkg::MODE_WIDTH-1:0];
        gtm_pkg::REG_COS_AZIMUTH:        cos_az   <= cfg_data;
        gtm_pkg::REG_SIN_AZIMUTH:        sin_az   <= cfg_data;
        gtm_pkg::REG_COS_DOUBLE_AZIMUTH: cos_2az  <= cfg_data;
        gtm_pkg::REG_SIN_DOUBLE_AZIMUTH: sin_2az  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Code 3 decodes as full: the high bit wins.
  always_comb begin
    if (mode_reg[1]) begin
      mode = gtm_pkg::MODE_FULL;
    end else if (mode_reg[0]) begin
      mode = gtm_pkg::MODE_DEV;
    end else begin
      mode = gtm_pkg::MODE_ISO;
    end
  end

  assign push_valid    = samples.valid;
  assign samples.ready = push_ready;
  assign push_data     = {samples.radial_strike_slip,     samples.radial_dip_slip,
                          samples.radial_dip_45,          samples.radial_explosion,
                          samples.vertical_strike_slip,   samples.vertical_dip_slip,
                          samples.vertical_dip_45,        samples.vertical_explosion,
                          samples.transverse_strike_slip, samples.transverse_dip_slip};

endmodule

`default_nettype wire

>>> hw/rtl/gtm_queue.sv
// Short sample queue between the front end and the rotation back end.
`default_nettype none

module gtm_queue #(
  parameter int WIDTH = gtm_pkg::NUM_TRACES * gtm_pkg::SAMPLE_WIDTH_DEF,
  parameter int DEPTH = gtm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gtm_back.sv
// Back end: channel sequencer, product stage, sum/round/saturate stage, output register.
`default_nettype none

module gtm_back #(
  parameter int SAMPLE_WIDTH = gtm_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = gtm_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        item_valid,
  output logic                                             item_ready,
  input  wire logic [gtm_pkg::NUM_TRACES*SAMPLE_WIDTH-1:0] item_data,
  input  wire gtm_pkg::mode_t                              mode,
  input  wire logic signed [COEF_WIDTH-1:0]                cos_az,
  input  wire logic signed [COEF_WIDTH-1:0]                sin_az,
  input  wire logic signed [COEF_WIDTH-1:0]                cos_2az,
  input  wire logic signed [COEF_WIDTH-1:0]                sin_2az,
  gtm_result_if.source                                     results
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;
  localparam int PW = SW + CW;
  localparam int AW = SW + CW + 3;

  localparam logic signed [CW-1:0] K_THIRD =
    CW'(((longint'(1) << (CW + 1)) + 3) / 6);
  localparam logic signed [CW-1:0] K_SIXTH =
    CW'(((longint'(1) << (CW + 1)) + 6) / 12);
  localparam logic signed [AW-1:0] HALF_LSB = AW'(longint'(1) << (CW - 1));
  localparam logic signed [AW-1:0] SAT_HI   = AW'((longint'(1) << (SW - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO   = AW'(-(longint'(1) << (SW - 1)));

  function automatic logic signed [AW-1:0] ext(input logic signed [PW-1:0] x);
    ext = AW'(x);
  endfunction

  // Round to nearest (ties up), then clamp to the sample range.
  function automatic logic signed [SW-1:0] finish(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] r;
    r = (acc + HALF_LSB) >>> CW;
    if (r > SAT_HI) begin
      finish = SW'(SAT_HI);
    end else if (r < SAT_LO) begin
      finish = SW'(SAT_LO);
    end else begin
      finish = SW'(r);
    end
  endfunction

  logic signed [SW-1:0] tr [gtm_pkg::NUM_TRACES];

  always_comb begin
    for (int i = 0; i < gtm_pkg::NUM_TRACES; i++) begin
      tr[i] = item_data[(gtm_pkg::NUM_TRACES - 1 - i) * SW +: SW];
    end
  end

  gtm_pkg::ch_t ch;
  gtm_pkg::ch_t ch_next;
  logic         advance;
  logic         take;
  logic         res_valid;

  // Stall the whole pipe only while the output register holds an untaken beat.
  assign advance    = !res_valid || results.ready;
  assign take       = item_valid && advance;
  assign item_ready = advance && (ch == gtm_pkg::CH_TRANSVERSE);

  logic signed [SW-1:0] op_a;
  logic signed [SW-1:0] op_b;
  logic signed [SW-1:0] op_dd;
  logic signed [SW-1:0] op_ep;

  always_comb begin
    case (ch)
      gtm_pkg::CH_RADIAL: begin
        ch_next = gtm_pkg::CH_VERTICAL;
        op_a    = tr[gtm_pkg::TR_RSS];
        op_b    = tr[gtm_pkg::TR_RDS];
        op_dd   = tr[gtm_pkg::TR_RDD];
        op_ep   = tr[gtm_pkg::TR_REP];
      end
      gtm_pkg::CH_VERTICAL: begin
        ch_next = gtm_pkg::CH_TRANSVERSE;
        op_a    = tr[gtm_pkg::TR_ZSS];
        op_b    = tr[gtm_pkg::TR_ZDS];
        op_dd   = tr[gtm_pkg::TR_ZDD];
        op_ep   = tr[gtm_pkg::TR_ZEP];
      end
      gtm_pkg::CH_TRANSVERSE: begin
        ch_next = gtm_pkg::CH_RADIAL;
        op_a    = tr[gtm_pkg::TR_TSS];
        op_b    = tr[gtm_pkg::TR_TDS];
        op_dd   = '0;
        op_ep   = '0;
      end
      default: begin
        ch_next = gtm_pkg::CH_RADIAL;
        op_a    = '0;
        op_b    = '0;
        op_dd   = '0;
        op_ep   = '0;
      end
    endcase
  end

  // Product stage.
  logic                 st1_valid;
  gtm_pkg::ch_t         st1_ch;
  logic signed [PW-1:0] p_c2a;
  logic signed [PW-1:0] p_s2a;
  logic signed [PW-1:0] p_cab;
  logic signed [PW-1:0] p_sab;
  logic signed [PW-1:0] p_k3dd;
  logic signed [PW-1:0] p_k6dd;
  logic signed [PW-1:0] p_k3ep;
  logic signed [PW-1:0] p_hdd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch        <= gtm_pkg::CH_RADIAL;
      st1_valid <= 1'b0;
    end else begin
      if (take) begin
        ch <= ch_next;
      end
      if (advance) begin
        st1_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      st1_ch <= ch;
      p_c2a  <= op_a * cos_2az;
      p_s2a  <= op_a * sin_2az;
      p_cab  <= op_b * cos_az;
      p_sab  <= op_b * sin_az;
      p_k3dd <= op_dd * K_THIRD;
      p_k6dd <= op_dd * K_SIXTH;
      p_k3ep <= op_ep * K_THIRD;
      p_hdd  <= PW'(op_dd) <<< (CW - 1);
    end
  end

  // Sum stage.
  logic signed [AW-1:0] acc_xx;
  logic signed [AW-1:0] acc_xy;
  logic signed [AW-1:0] acc_xz;
  logic signed [AW-1:0] acc_yy;
  logic signed [AW-1:0] acc_yz;
  logic signed [AW-1:0] acc_zz;

  always_comb begin
    acc_xx = '0;
    acc_xy = '0;
    acc_xz = '0;
    acc_yy = '0;
    acc_yz = '0;
    acc_zz = '0;
    case (st1_ch)
      gtm_pkg::CH_RADIAL, gtm_pkg::CH_VERTICAL: begin
        case (mode)
          gtm_pkg::MODE_ISO: begin
            acc_xx = ext(p_k3ep);
            acc_yy = ext(p_k3ep);
            acc_zz = ext(p_k3ep);
          end
          gtm_pkg::MODE_DEV: begin
            acc_xx = ext(p_c2a) - ext(p_hdd);
            acc_yy = -ext(p_c2a) - ext(p_hdd);
            acc_xy = ext(p_s2a) <<< 1;
            acc_xz = ext(p_cab) <<< 1;
            acc_yz = ext(p_sab) <<< 1;
          end
          default: begin
            acc_xx = ext(p_c2a) - ext(p_k6dd) + ext(p_k3ep);
            acc_yy = -ext(p_c2a) - ext(p_k6dd) + ext(p_k3ep);
            acc_xy = ext(p_s2a) <<< 1;
            acc_xz = ext(p_cab) <<< 1;
            acc_yz = ext(p_sab) <<< 1;
            acc_zz = ext(p_k3dd) + ext(p_k3ep);
          end
        endcase
      end
      gtm_pkg::CH_TRANSVERSE: begin
        if (mode != gtm_pkg::MODE_ISO) begin
          acc_xx = ext(p_s2a);
          acc_xy = -(ext(p_c2a) <<< 1);
          acc_xz = ext(p_sab) <<< 1;
          acc_yy = -ext(p_s2a);
          acc_yz = -(ext(p_cab) <<< 1);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  gtm_pkg::ch_t         res_ch;
  logic signed [SW-1:0] res_xx;
  logic signed [SW-1:0] res_xy;
  logic signed [SW-1:0] res_xz;
  logic signed [SW-1:0] res_yy;
  logic signed [SW-1:0] res_yz;
  logic signed [SW-1:0] res_zz;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && st1_valid) begin
      res_ch <= st1_ch;
      res_xx <= finish(acc_xx);
      res_xy <= finish(acc_xy);
      res_xz <= finish(acc_xz);
      res_yy <= finish(acc_yy);
      res_yz <= finish(acc_yz);
      res_zz <= finish(acc_zz);
    end
  end

  assign results.valid          = res_valid;
  assign results.channel        = res_ch;
  assign results.elem_xx        = res_xx;
  assign results.elem_xy        = res_xy;
  assign results.elem_xz        = res_xz;
  assign results.elem_yy        = res_yy;
  assign results.elem_yz        = res_yz;
  assign results.elem_zz        = res_zz;
  assign results.last_of_sample = (res_ch == gtm_pkg::CH_TRANSVERSE);

endmodule

`default_nettype wire
